@@ rtl/core/tfdr_pkg.sv @@
// ----------------------------------------------------------------------------
// tfdr_pkg
// Shared types and constants for the tagged frame delay ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tfdr_pkg;

  // Fixed field widths
  localparam int POS_W  = 48;
  localparam int WORD_W = 32;
  localparam int CMD_W  = 2;
  localparam int CH_W   = 2;
  localparam int CAP_W  = 11;

  // Input word command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_ACTIVE_CHANNELS = 1'b0,
    REG_CAPACITY_FRAMES = 1'b1
  } reg_idx_t;

  // Register reset values
  localparam logic [CH_W-1:0]  ACTIVE_CHANNELS_RST = 2'd2;
  localparam logic [CAP_W-1:0] CAPACITY_FRAMES_RST = 11'd1024;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE,
    ST_READ,
    ST_LOOKUP,
    ST_CLEAR
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/tagged_frame_delay_ring_unit.sv @@
// ----------------------------------------------------------------------------
// tagged_frame_delay_ring_unit
// Multi-channel frame store addressed by absolute frame position, with a
// position tag and valid bit per slot and an iterative modulo for the slot.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / data                              | side bands
//  --------+-----------+-------------------------------------------+-----------------
//  s_*     | in        | position, channels_present, ch0, ch1      | tuser=command, tlast=block_end
//  m_*     | out       | out_ch0, out_ch1                          | tuser=hit, tlast=last_of_block
//  APB     | in/out    | 0x0 active_channels, 0x4 capacity_frames  | pready tied high
//
//  A write or read word first runs its position through a restoring divider that
//  retires one of the 48 position bits per cycle to form the slot index, then a
//  write step, or on a read a memory read step and a lookup step (plus any output stall).
//  A clear word, any register write, and reset start a clearing pass that
//  walks all DEPTH tag entries one entry per cycle, accepting no word meanwhile.
//  A finished result waits in the output register while the next word runs;
//  a read stalls in its lookup step only if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_frame_delay_ring_unit #(
  parameter int DEPTH        = 1024,
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,

  // Input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [47:0] position, [49:48] channels_present, [81:50] sample_ch0,
  // [113:82] sample_ch1, [119:114] zero
  input  wire logic [119:0] s_tdata,
  // [1:0] command
  input  wire logic [1:0]   s_tuser,
  input  wire logic         s_tlast,

  // Output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [31:0] out_ch0, [63:32] out_ch1
  output logic [63:0]       m_tdata,
  // [0] hit
  output logic              m_tuser,
  output logic              m_tlast,

  // Configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int POS_W = tfdr_pkg::POS_W;
  localparam int WW    = tfdr_pkg::WORD_W;
  localparam int SW    = NUM_CHANNELS * WW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [tfdr_pkg::CH_W-1:0]  active_channels;
  logic [tfdr_pkg::CAP_W-1:0] capacity_frames;
  logic                       cfg_wr;
  tfdr_pkg::reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = tfdr_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= tfdr_pkg::ACTIVE_CHANNELS_RST;
      capacity_frames <= tfdr_pkg::CAPACITY_FRAMES_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tfdr_pkg::REG_ACTIVE_CHANNELS: active_channels <= pwdata[tfdr_pkg::CH_W-1:0];
        tfdr_pkg::REG_CAPACITY_FRAMES: capacity_frames <= pwdata[tfdr_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tfdr_pkg::REG_ACTIVE_CHANNELS: prdata = {30'd0, active_channels};
      tfdr_pkg::REG_CAPACITY_FRAMES: prdata = {21'd0, capacity_frames};
      default:                       prdata = '0;
    endcase
  end

  // Clamp registers to what the storage supports
  logic [1:0]    eff_ch;
  logic [31:0]   eff_cap32;
  logic [CW-1:0] eff_cap;

  always_comb begin
    if (active_channels == 2'd0) begin
      eff_ch = 2'd1;
    end else if (32'(active_channels) > 32'(NUM_CHANNELS)) begin
      eff_ch = 2'(NUM_CHANNELS);
    end else begin
      eff_ch = active_channels;
    end
    if (capacity_frames == '0) begin
      eff_cap32 = 32'd1;
    end else if (32'(capacity_frames) > 32'(DEPTH)) begin
      eff_cap32 = 32'(DEPTH);
    end else begin
      eff_cap32 = 32'(capacity_frames);
    end
  end

  assign eff_cap = eff_cap32[CW-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  tfdr_pkg::state_t state, state_next;
  tfdr_pkg::cmd_t   in_cmd;

  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] pos_shift;
  logic [1:0]       present_q;
  logic [WW-1:0]    word0_q;
  logic [WW-1:0]    word1_q;
  logic             last_q;
  logic             is_read;
  logic [5:0]       bit_cnt;
  logic [CW-1:0]    rem;
  logic [AW-1:0]    clr_idx;
  logic [AW-1:0]    slot;

  logic             accept;
  logic             div_step;
  logic             clr_start;
  logic             clr_step;
  logic             tag_we;
  logic             tag_wvalid;
  logic             smp_we;
  logic             out_load;

  assign in_cmd = tfdr_pkg::cmd_t'(s_tuser);
  assign slot   = rem[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tfdr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    div_step   = 1'b0;
    clr_start  = 1'b0;
    clr_step   = 1'b0;
    tag_we     = 1'b0;
    tag_wvalid = 1'b0;
    smp_we     = 1'b0;
    out_load   = 1'b0;
    case (state)
      tfdr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept = 1'b1;
          case (in_cmd)
            tfdr_pkg::CMD_WRITE,
            tfdr_pkg::CMD_READ:  state_next = tfdr_pkg::ST_DIVIDE;
            tfdr_pkg::CMD_CLEAR: begin
              state_next = tfdr_pkg::ST_CLEAR;
              clr_start  = 1'b1;
            end
            default: state_next = tfdr_pkg::ST_IDLE;
          endcase
        end
      end
      tfdr_pkg::ST_DIVIDE: begin
        div_step = 1'b1;
        if (bit_cnt == 6'(POS_W - 1)) begin
          state_next = is_read ? tfdr_pkg::ST_READ : tfdr_pkg::ST_WRITE;
        end
      end
      tfdr_pkg::ST_WRITE: begin
        tag_we     = 1'b1;
        tag_wvalid = 1'b1;
        smp_we     = 1'b1;
        state_next = tfdr_pkg::ST_IDLE;
      end
      tfdr_pkg::ST_READ: begin
        state_next = tfdr_pkg::ST_LOOKUP;
      end
      tfdr_pkg::ST_LOOKUP: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = tfdr_pkg::ST_IDLE;
        end
      end
      tfdr_pkg::ST_CLEAR: begin
        tag_we   = 1'b1;
        clr_step = 1'b1;
        if (clr_idx == AW'(DEPTH - 1)) begin
          state_next = tfdr_pkg::ST_IDLE;
        end
      end
      default: state_next = tfdr_pkg::ST_IDLE;
    endcase
    // Any register write restarts the clearing pass
    if (cfg_wr) begin
      state_next = tfdr_pkg::ST_CLEAR;
      clr_start  = 1'b1;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_q     <= s_tdata[47:0];
      present_q <= s_tdata[49:48];
      word0_q   <= s_tdata[81:50];
      word1_q   <= s_tdata[113:82];
      last_q    <= s_tlast;
      is_read   <= (in_cmd == tfdr_pkg::CMD_READ);
    end
  end

  // Restoring modulo: one position bit per cycle, MSB first
  logic [CW:0] rem_shift;
  logic [CW:0] rem_sub;

  assign rem_shift = {rem, pos_shift[POS_W-1]};
  assign rem_sub   = rem_shift - {1'b0, eff_cap};

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_shift <= s_tdata[47:0];
      rem       <= '0;
      bit_cnt   <= '0;
    end else if (div_step) begin
      pos_shift <= {pos_shift[POS_W-2:0], 1'b0};
      bit_cnt   <= bit_cnt + 6'd1;
      if (rem_shift >= {1'b0, eff_cap}) begin
        rem <= rem_sub[CW-1:0];
      end else begin
        rem <= rem_shift[CW-1:0];
      end
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst || clr_start) begin
      clr_idx <= '0;
    end else if (clr_step) begin
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Tag and sample memories
  // --------------------------------------------------------------------------
  logic [POS_W:0] tag_mem [DEPTH];
  logic [SW-1:0]  smp_mem [DEPTH];
  logic [POS_W:0] tag_q;
  logic [SW-1:0]  smp_q;
  logic [AW-1:0]  tag_waddr;
  logic [SW-1:0]  smp_wdata;

  assign tag_waddr = (state == tfdr_pkg::ST_CLEAR) ? clr_idx : slot;

  // Zero channels the source did not supply or that are inactive
  always_comb begin
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      if (2'(ch) < present_q && 2'(ch) < eff_ch) begin
        smp_wdata[ch*WW +: WW] = (ch == 0) ? word0_q : word1_q;
      end else begin
        smp_wdata[ch*WW +: WW] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= {tag_wvalid, pos_q};
    end
    tag_q <= tag_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[slot] <= smp_wdata;
    end
    smp_q <= smp_mem[slot];
  end

  // --------------------------------------------------------------------------
  // Lookup and output register
  // --------------------------------------------------------------------------
  logic          hit_next;
  logic [WW-1:0] out0_next;
  logic [WW-1:0] out1_next;

  assign hit_next = tag_q[POS_W] && (tag_q[POS_W-1:0] == pos_q);

  always_comb begin
    out0_next = hit_next ? smp_q[WW-1:0] : '0;
    out1_next = '0;
    if (NUM_CHANNELS > 1 && hit_next && eff_ch > 2'd1) begin
      out1_next = smp_q[SW-1 -: WW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {out1_next, out0_next};
      m_tuser <= hit_next;
      m_tlast <= last_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rem_below_cap: assert property (@(posedge clk) disable iff (rst)
    (state == tfdr_pkg::ST_DIVIDE) |-> ({1'b0, rem} < {1'b0, eff_cap}))
    else $error("modulo remainder reached the capacity");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (state == tfdr_pkg::ST_CLEAR) && (clr_idx == '0))
    else $error("register write did not restart the clearing pass");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == tfdr_pkg::ST_CLEAR) |-> !s_tready)
    else $error("word accepted during the clearing pass");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (state == tfdr_pkg::ST_CLEAR))
    else $error("reset did not start the clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> !$past(out_load))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ dv/tagged_frame_delay_ring_checker.sv @@
// ----------------------------------------------------------------------------
// tagged_frame_delay_ring_checker
// Watches the input stream, the output stream and the configuration port of
// the frame delay ring, keeps its own copy of the slot store, tags and
// registers, predicts every read result and compares each returned word
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tagged_frame_delay_ring_checker
  import tfdr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  // [47:0] position, [49:48] channels_present, [81:50] sample_ch0,
  // [113:82] sample_ch1, [119:114] zero
  input  logic [119:0] s_tdata,
  // [1:0] command
  input  logic [1:0]   s_tuser,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] out_ch0, [63:32] out_ch1
  input  logic [63:0]  m_tdata,
  // [0] hit
  input  logic         m_tuser,
  input  logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 1024;
  localparam int CHANNELS   = 2;

  typedef struct packed {
    logic [WORD_W-1:0] ch0;
    logic [WORD_W-1:0] ch1;
    logic              hit;
    logic              last;
  } frame_result_t;

  frame_result_t     expected_frames[$];
  logic [WORD_W-1:0] frame_word  [0:RING_DEPTH*CHANNELS-1];
  logic [POS_W-1:0]  frame_tag   [0:RING_DEPTH-1];
  bit                frame_valid [0:RING_DEPTH-1];
  logic [CH_W-1:0]   channels_reg;
  logic [CAP_W-1:0]  capacity_reg;
  int                error_count = 0;

  // Clamp the channel register to the supported range
  function automatic int channels_in_use();
    if (channels_reg == 0) return 1;
    if (channels_reg > CHANNELS) return CHANNELS;
    return channels_reg;
  endfunction

  // Slot index of a position under the clamped capacity
  function automatic int slot_of(logic [POS_W-1:0] pos);
    logic [POS_W-1:0] cap;
    cap = (capacity_reg == 0) ? 1 :
          (capacity_reg > RING_DEPTH) ? RING_DEPTH : capacity_reg;
    return int'(pos % cap);
  endfunction

  function automatic void invalidate_tags();
    foreach (frame_valid[i]) frame_valid[i] = 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Update the shadow store for one command word; queue a result on read
  task automatic apply_frame_command(input logic [1:0] cmd, input logic [119:0] data,
                                     input logic last);
    logic [POS_W-1:0]  pos;
    logic [CH_W-1:0]   present;
    int                slot;
    int                chans;
    frame_result_t     res;
    pos     = data[47:0];
    present = data[49:48];
    slot    = slot_of(pos);
    chans   = channels_in_use();
    case (cmd)
      CMD_WRITE: begin
        frame_word[slot*CHANNELS]   = (present > 0) ? data[81:50] : '0;
        frame_word[slot*CHANNELS+1] = (chans > 1 && present > 1) ? data[113:82] : '0;
        frame_tag[slot]             = pos;
        frame_valid[slot]           = 1'b1;
      end
      CMD_READ: begin
        res      = '0;
        res.hit  = frame_valid[slot] && frame_tag[slot] == pos;
        res.last = last;
        if (res.hit) begin
          res.ch0 = frame_word[slot*CHANNELS];
          if (chans > 1) res.ch1 = frame_word[slot*CHANNELS+1];
        end
        expected_frames.push_back(res);
      end
      CMD_CLEAR: begin
        invalidate_tags();
      end
      default: begin
        // unknown command: drop it
      end
    endcase
  endtask

  // Compare one returned word against the oldest prediction
  task automatic check_frame_result();
    frame_result_t exp;
    if (expected_frames.size() == 0) begin
      report_mismatch($sformatf("unexpected result word data=%h", m_tdata));
    end else begin
      exp = expected_frames.pop_front();
      if (m_tdata[31:0] !== exp.ch0)
        report_mismatch($sformatf("out_ch0 %h, expected %h", m_tdata[31:0], exp.ch0));
      if (m_tdata[63:32] !== exp.ch1)
        report_mismatch($sformatf("out_ch1 %h, expected %h", m_tdata[63:32], exp.ch1));
      if (m_tuser !== exp.hit)
        report_mismatch($sformatf("hit %b, expected %b", m_tuser, exp.hit));
      if (m_tlast !== exp.last)
        report_mismatch($sformatf("last_of_block %b, expected %b", m_tlast, exp.last));
    end
  endtask

  // Sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      channels_reg = ACTIVE_CHANNELS_RST;
      capacity_reg = CAPACITY_FRAMES_RST;
      invalidate_tags();
      expected_frames.delete();
    end else begin
      if (m_tvalid && m_tready) check_frame_result();
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ACTIVE_CHANNELS) channels_reg = pwdata[CH_W-1:0];
        else capacity_reg = pwdata[CAP_W-1:0];
        invalidate_tags();
      end
      if (s_tvalid && s_tready) apply_frame_command(s_tuser, s_tdata, s_tlast);
    end
    pending    <= expected_frames.size();
    mismatches <= error_count;
  end

endmodule

@@ dv/tagged_frame_delay_ring_unit_test.sv @@
// ----------------------------------------------------------------------------
// tagged_frame_delay_ring_unit_test
// Drives the frame delay ring with a directed set of writes, reads and clears
// followed by random delay-line traffic under several channel and capacity
// settings, with bursty input and a stalling receiver; the checker module
// predicts and compares every read result.
// ----------------------------------------------------------------------------
module tagged_frame_delay_ring_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tfdr_pkg::*;

  // Wait long enough for a clearing pass plus one full read word
  localparam int SETTLE_CYCLES = 1100;
  localparam int PHASE_COUNT   = 8;
  localparam int RECENT_MAX    = 24;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [47:0] position, [49:48] channels_present, [81:50] sample_ch0,
  // [113:82] sample_ch1, [119:114] zero
  logic [119:0] s_tdata  = '0;
  // [1:0] command
  logic [1:0]   s_tuser  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [31:0] out_ch0, [63:32] out_ch1
  logic [63:0]  m_tdata;
  // [0] hit
  logic         m_tuser;
  logic         m_tlast;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           mismatches;
  int           pending;

  // Stimulus bookkeeping
  int               cur_cap    = 1024;
  int               burst_left = 0;
  int               stall_left = 0;
  int               stall_mode = 0;
  bit               slot_written [0:1023];
  logic [POS_W-1:0] recent_writes[$];
  logic [POS_W-1:0] stream_head;

  int phase_chan [PHASE_COUNT] = '{1, 2, 0, 3, 2, 1, 2, 2};
  int phase_cap  [PHASE_COUNT] = '{1024, 1, 7, 0, 1500, 2047, 13, 1025};

  tagged_frame_delay_ring_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tagged_frame_delay_ring_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: switch between always ready, coin flip and long stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [POS_W-1:0] capacity_in_use();
    if (cur_cap == 0) return 1;
    if (cur_cap > 1024) return 1024;
    return cur_cap;
  endfunction

  function automatic logic [POS_W-1:0] random_position();
    logic [31:0] upper;
    upper = $urandom();
    return {upper[15:0], $urandom()};
  endfunction

  // Send one word in bursts with random gaps; track written slots
  task automatic send_word(input cmd_t cmd, input logic [POS_W-1:0] pos,
                           input logic [1:0] present, input logic [31:0] w0,
                           input logic [31:0] w1, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    if (cmd == CMD_WRITE) begin
      slot_written[pos % capacity_in_use()] = 1'b1;
      recent_writes.push_back(pos);
      if (recent_writes.size() > RECENT_MAX) void'(recent_writes.pop_front());
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, w1, w0, present, pos};
    s_tuser  <= cmd;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold the input, wait for every result, then let any clear pass finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(CMD_WRITE, 48'd0, 2'd2, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_word(CMD_READ, 48'd0, 2'd0, 32'h0, 32'h0, 1'b1);
    send_word(CMD_WRITE, 48'hFFFF_FFFF_FFFF, 2'd2, 32'h0, 32'hFFFF_FFFF, 1'b1);
    send_word(CMD_READ, 48'hFFFF_FFFF_FFFF, 2'd0, 32'h0, 32'h0, 1'b0);
    // same slot, different tag
    send_word(CMD_READ, 48'd1024, 2'd0, 32'h0, 32'h0, 1'b0);
    // no channels supplied, then only the first one
    send_word(CMD_WRITE, 48'd5, 2'd0, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
    send_word(CMD_READ, 48'd5, 2'd0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_WRITE, 48'd6, 2'd1, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0);
    send_word(CMD_READ, 48'd6, 2'd0, 32'h0, 32'h0, 1'b1);
    send_word(CMD_CLEAR, 48'd0, 2'd0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_READ, 48'd0, 2'd0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_READ, 48'hFFFF_FFFF_FFFF, 2'd0, 32'h0, 32'h0, 1'b1);
    // unknown command
    send_word(cmd_t'(2'd3), 48'd0, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_word(CMD_WRITE, 48'd2048, 2'd2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
    send_word(CMD_READ, 48'd2048, 2'd0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_READ, 48'd0, 2'd0, 32'h0, 32'h0, 1'b0);
    send_word(CMD_WRITE, 48'h8000_0000_0000, 2'd2, 32'h0000_0001, 32'h8000_0000, 1'b1);
    send_word(CMD_READ, 48'h8000_0000_0000, 2'd0, 32'h0, 32'h0, 1'b1);
  endtask

  // Delay-line traffic: stream writes, reads of recent frames and aliases
  task automatic run_random(input int count);
    int               r;
    int               k;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cap;
    logic [1:0]       present;
    cmd_t             cmd;
    for (int n = 0; n < count; n++) begin
      cap     = capacity_in_use();
      r       = $urandom_range(0, 99);
      r       = (recent_writes.size() == 0 && r >= 45 && r < 90) ? 0 : r;
      present = 2'd2;
      if (r < 45 || r >= 95) begin
        cmd = CMD_WRITE;
        if (r >= 95 || $urandom_range(0, 19) == 0) stream_head = random_position();
        pos = stream_head;
        stream_head = stream_head + 1;
        k = $urandom_range(0, 9);
        present = (k < 6) ? 2'd2 : (k < 8) ? 2'd1 : 2'd0;
      end else if (r < 90) begin
        cmd = CMD_READ;
        pos = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        k   = $urandom_range(0, 99);
        if (k >= 65 && k < 85) begin
          // alias onto the same slot with another tag
          if (pos > 48'hFFFF_FFFF_0000) pos = pos - cap * $urandom_range(1, 3);
          else pos = pos + cap * $urandom_range(1, 3);
        end else if (k >= 85) begin
          if (slot_written[random_position() % cap]) pos = random_position();
        end
      end else if (r < 93) begin
        cmd = CMD_CLEAR;
        pos = random_position();
      end else begin
        cmd = cmd_t'(2'd3);
        pos = random_position();
      end
      // a random read position must still land on a written slot
      if (cmd == CMD_READ && !slot_written[pos % cap])
        pos = recent_writes[recent_writes.size() - 1];
      send_word(cmd, pos, present, $urandom(), $urandom(), $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    stream_head = random_position();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(100);
    for (int i = 0; i < PHASE_COUNT; i++) begin
      wait_idle();
      apb_write(REG_ACTIVE_CHANNELS, ($urandom() & ~32'h3) | phase_chan[i]);
      repeat (SETTLE_CYCLES) @(posedge clk);
      apb_write(REG_CAPACITY_FRAMES, ($urandom() & ~32'h7FF) | phase_cap[i]);
      cur_cap = phase_cap[i];
      repeat (SETTLE_CYCLES) @(posedge clk);
      recent_writes.delete();
      run_random(120);
    end
    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("tagged_frame_delay_ring_unit test passed");
    end else begin
      $display("tagged_frame_delay_ring_unit test failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #2_000_000;
    $display("tagged_frame_delay_ring_unit test failed");
    $finish;
  end

endmodule
